@@ rtl/ula_pkg.sv @@
// Shared types and constants for the UART line assembler.
`default_nettype none

package ula_pkg;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_RETURN  = 8'h0D;

   localparam logic OP_DATA  = 1'b0;
   localparam logic OP_ERROR = 1'b1;

   localparam logic KIND_LINE  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic [9:0] error_code;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] line_byte;
      logic       last;
      logic [9:0] reported_error;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic write_byte;
      logic clear;
      logic start_line;
      logic capture_error;
      logic read_en;
      logic load_byte;
      logic load_error;
      logic advance;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_error;
      logic is_newline;
      logic line_empty;
      logic last_byte;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/uart_line_assembler.sv @@
// Top level: UART line assembler (controller plus datapath).
// Plain data byte: written to the line store, no result; next byte may follow at once.
// Newline with kept bytes: each byte passes the READ state (store read port), then the SEND
//   state (result register); input stalled until the last byte is loaded into the result
//   register, and while a pending result is held off by rsp_stall.
// Error event: the error code is captured, then loaded into the result register in the ERROR
//   state; input stalled until then, and while a pending result is held off by rsp_stall.
// Synchronous active-high reset empties the line; store contents stay undefined.
`default_nettype none

module uart_line_assembler
   import ula_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   // command / status bundles between the FSM and the datapath
   cmd_type cmd;
   sts_type sts;

   // FSM: owns the request handshake and sequences each transaction
   ula_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: line store RAM, counters, and the result register that
   // holds a finished transaction while the sink stalls
   ula_dp #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ rtl/ula_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ula_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/ula_ctrl.sv @@
// Control FSM: sequences byte writes, line readout and error reports.
`default_nettype none

module ula_ctrl
   import ula_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND,
      ST_ERROR
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (sts.is_error) begin
                  cmd.clear         = 1'b1;
                  cmd.capture_error = 1'b1;
                  state_in          = ST_ERROR;
               end else if (sts.is_newline) begin
                  cmd.clear = 1'b1;
                  if (!sts.line_empty) begin
                     cmd.start_line = 1'b1;
                     state_in       = ST_READ;
                  end
               end else begin
                  cmd.write_byte = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.read_en = 1'b1;
            state_in    = ST_SEND;
         end
         ST_SEND: begin
            if (sts.out_free) begin
               cmd.load_byte = 1'b1;
               if (sts.last_byte) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_ERROR: begin
            if (sts.out_free) begin
               cmd.load_error = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // results are only loaded while busy, never in idle
   a_no_load_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(cmd.load_byte || cmd.load_error))
      else $error("result loaded while idle");

   // a readout read is always followed by the send step
   a_read_then_send: assert property (@(posedge clock) disable iff (reset)
      cmd.read_en |=> (state_ff == ST_SEND))
      else $error("read not followed by send");

   // no input is taken while a line or error report is in flight
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_line || cmd.capture_error) |=> req_stall)
      else $error("input accepted during readout");

endmodule

`default_nettype wire

@@ rtl/ula_dp.sv @@
// Datapath: line store, fill and keep counters, readout index, result register.
`default_nettype none

module ula_dp
   import ula_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_payload,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam int AW = $clog2(LINE_DEPTH);
   localparam logic [CW-1:0] FULL = CW'(LINE_DEPTH);

   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic [CW-1:0] len_ff,  len_in;
   logic [CW-1:0] idx_ff,  idx_in;
   logic [9:0]    err_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff;

   logic [CW-1:0] eff_fill, eff_keep, fill_next, idx_next;
   logic [7:0]    rd_data;
   logic          out_free;

   // a full store is dropped before the next data byte is handled
   assign eff_fill  = (fill_ff == FULL) ? '0 : fill_ff;
   assign eff_keep  = (fill_ff == FULL) ? '0 : keep_ff;
   assign fill_next = CW'(eff_fill + 1'b1);
   assign idx_next  = CW'(idx_ff + 1'b1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   ula_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.write_byte),
      .wr_addr (eff_fill[AW-1:0]),
      .wr_data (req_payload.data_byte),
      .rd_en   (cmd.read_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      sts.is_error   = (req_payload.op == OP_ERROR);
      sts.is_newline = (req_payload.data_byte == CH_NEWLINE);
      sts.line_empty = (eff_keep == '0);
      sts.last_byte  = (idx_next == len_ff);
      sts.out_free   = out_free;
   end

   always_comb begin
      fill_in = fill_ff;
      keep_in = keep_ff;
      if (cmd.clear) begin
         fill_in = '0;
         keep_in = '0;
      end else if (cmd.write_byte) begin
         fill_in = fill_next;
         keep_in = (req_payload.data_byte != CH_RETURN) ? fill_next : eff_keep;
      end
      len_in = cmd.start_line ? eff_keep : len_ff;
      priority if (cmd.start_line) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_next;
      end else begin
         idx_in = idx_ff;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_byte || cmd.load_error) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         keep_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         keep_ff      <= keep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff <= len_in;
      idx_ff <= idx_in;
      if (cmd.capture_error) begin
         err_ff <= req_payload.error_code;
      end
      if (cmd.load_byte) begin
         rsp_ff.kind           <= KIND_LINE;
         rsp_ff.line_byte      <= rd_data;
         rsp_ff.last           <= sts.last_byte;
         rsp_ff.reported_error <= '0;
      end else if (cmd.load_error) begin
         rsp_ff.kind           <= KIND_ERROR;
         rsp_ff.line_byte      <= '0;
         rsp_ff.last           <= 1'b1;
         rsp_ff.reported_error <= err_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("fill count beyond store depth");

   a_keep_bound: assert property (@(posedge clock) disable iff (reset)
      keep_ff <= fill_ff)
      else $error("keep length beyond fill count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_byte || cmd.load_error) |-> out_free)
      else $error("pending result overwritten");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_ERROR) |-> rsp_ff.last)
      else $error("error report without last");

endmodule

`default_nettype wire
